// ----- rtl/core/tems_pkg.sv -----
// Shared types, constants and tone tables of the tone and effect sequencer.
package tems_pkg;

	localparam int CMD_W      = 2;
	localparam int NOW_W      = 32;
	localparam int EFF_W      = 3;
	localparam int FREQ_W     = 11;
	localparam int DUR_W      = 8;
	localparam int EFFECT_NUM = 6;

	localparam int MELODY_STEPS_DEF = 32;
	localparam int TIME_BITS_DEF    = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_MUTE    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [NOW_W-1:0] now_ms;
		logic [EFF_W-1:0] effect_id;
		logic             music_halted;
	} in_word_t;

	typedef struct packed {
		logic [FREQ_W-1:0] tone_freq;
		logic              tone_changed;
		logic              speaker_off;
	} out_word_t;

	typedef struct packed {
		logic [FREQ_W-1:0] hz;
		logic [DUR_W-1:0]  ms;
	} tone_step_t;

	// Melody: every odd step is a short rest, every even step a note.
	function automatic tone_step_t melody_step_rom(input logic [4:0] idx);
		tone_step_t r;
		r.ms = 8'd120;
		case (idx[4:1])
			4'd0:    r.hz = 11'd165;
			4'd1:    r.hz = 11'd196;
			4'd2:    r.hz = 11'd247;
			4'd3:    r.hz = 11'd330;
			4'd4:    r.hz = 11'd262;
			4'd5:    r.hz = 11'd330;
			4'd6:    r.hz = 11'd392;
			4'd7:    r.hz = 11'd523;
			4'd8:    r.hz = 11'd196;
			4'd9:    r.hz = 11'd247;
			4'd10:   r.hz = 11'd294;
			4'd11:   r.hz = 11'd392;
			4'd12:   r.hz = 11'd147;
			4'd13:   r.hz = 11'd185;
			4'd14:   r.hz = 11'd220;
			default: r.hz = 11'd294;
		endcase
		if (idx[0]) begin
			r.hz = '0;
			r.ms = 8'd35;
		end
		return r;
	endfunction

	function automatic tone_step_t effect_step_rom(input logic [EFF_W-1:0] sel,
		input logic [1:0] st);
		tone_step_t r;
		case ({sel, st})
			{3'd0, 2'd0}: r = '{hz: 11'd659,  ms: 8'd70};
			{3'd0, 2'd1}: r = '{hz: 11'd988,  ms: 8'd90};
			{3'd1, 2'd0}: r = '{hz: 11'd784,  ms: 8'd60};
			{3'd1, 2'd1}: r = '{hz: 11'd988,  ms: 8'd60};
			{3'd2, 2'd0}: r = '{hz: 11'd123,  ms: 8'd55};
			{3'd3, 2'd0}: r = '{hz: 11'd110,  ms: 8'd80};
			{3'd3, 2'd1}: r = '{hz: 11'd82,   ms: 8'd80};
			{3'd3, 2'd2}: r = '{hz: 11'd55,   ms: 8'd110};
			{3'd4, 2'd0}: r = '{hz: 11'd196,  ms: 8'd120};
			{3'd4, 2'd1}: r = '{hz: 11'd147,  ms: 8'd140};
			{3'd4, 2'd2}: r = '{hz: 11'd98,   ms: 8'd180};
			{3'd5, 2'd0}: r = '{hz: 11'd523,  ms: 8'd90};
			{3'd5, 2'd1}: r = '{hz: 11'd659,  ms: 8'd90};
			{3'd5, 2'd2}: r = '{hz: 11'd784,  ms: 8'd90};
			{3'd5, 2'd3}: r = '{hz: 11'd1047, ms: 8'd150};
			default:      r = '{hz: 11'd0,    ms: 8'd0};
		endcase
		return r;
	endfunction

	function automatic logic [2:0] effect_len(input logic [EFF_W-1:0] sel);
		logic [2:0] n;
		case (sel)
			3'd0:    n = 3'd2;
			3'd1:    n = 3'd2;
			3'd2:    n = 3'd1;
			3'd3:    n = 3'd3;
			3'd4:    n = 3'd3;
			3'd5:    n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- rtl/core/tems_chan_if.sv -----
// Valid/ready channel interface that carries one word of type T.
interface tems_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/tone_effect_music_sequencer.sv -----
// A word accepted into the input register is decoded and applied to the sequencer state in
// one pass between the two registers, and reaches the result register once that register is
// empty or its result is taken. Throughput: one word per cycle while rsp.ready stays high;
// the input register can take a new word while a result waits, and holds it until that
// result is taken. Reset (arst_n low, asynchronous) turns sound on, stops any effect, rewinds
// the melody and silences the speaker; both pipeline registers come up empty.
module tone_effect_music_sequencer #(
	parameter int MELODY_STEPS = tems_pkg::MELODY_STEPS_DEF,
	parameter int TIME_BITS    = tems_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tems_chan_if.sink   req,
	tems_chan_if.source rsp
);
	import tems_pkg::*;

	localparam int STEP_W = (MELODY_STEPS > 1) ? $clog2(MELODY_STEPS) : 1;
	localparam int EXT_W  = (STEP_W > 5) ? STEP_W : 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MELODY_STEPS - 1);

	// Input register.
	in_word_t req_s1;
	logic     valid_s1;

	// Result register.
	out_word_t rsp_data_q;
	logic      rsp_valid_q;

	// Sequencer state.
	logic                 sound_on_q;
	logic                 effect_busy_q;
	logic [EFF_W-1:0]     effect_sel_q;
	logic [1:0]           effect_step_q;
	logic                 step_running_q;
	logic [TIME_BITS-1:0] step_start_q;
	logic [STEP_W-1:0]    melody_step_q;
	logic [FREQ_W-1:0]    tone_q;

	logic                 sound_on_n;
	logic                 effect_busy_n;
	logic [EFF_W-1:0]     effect_sel_n;
	logic [1:0]           effect_step_n;
	logic                 step_running_n;
	logic [TIME_BITS-1:0] step_start_n;
	logic [STEP_W-1:0]    melody_step_n;
	logic [FREQ_W-1:0]    tone_n;
	logic                 off_n;

	logic                 advance;
	logic                 req_take;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	tone_step_t           eff_cur;
	tone_step_t           eff_nxt;
	tone_step_t           mel_cur;
	tone_step_t           mel_nxt;
	logic [2:0]           eff_st_inc;
	logic [STEP_W-1:0]    mel_step_inc;
	logic [EXT_W-1:0]     mel_cur_ext;
	logic [EXT_W-1:0]     mel_nxt_ext;
	logic                 eff_done;
	logic                 mel_done;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_take  = req.valid && req.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	assign now_t   = req_s1.now_ms[TIME_BITS-1:0];
	assign elapsed = now_t - step_start_q;

	// Effect step lookups: the running step and the one after it.
	assign eff_cur    = effect_step_rom(effect_sel_q, effect_step_q);
	assign eff_st_inc = {1'b0, effect_step_q} + 3'd1;
	assign eff_nxt    = effect_step_rom(effect_sel_q, eff_st_inc[1:0]);
	assign eff_done   = elapsed >= TIME_BITS'(eff_cur.ms);

	// The 32-entry melody table repeats when the melody is longer.
	assign mel_step_inc = (melody_step_q == LAST_STEP) ? '0 : melody_step_q + 1'b1;
	assign mel_cur_ext  = EXT_W'(melody_step_q);
	assign mel_nxt_ext  = EXT_W'(mel_step_inc);
	assign mel_cur      = melody_step_rom(mel_cur_ext[4:0]);
	assign mel_nxt      = melody_step_rom(mel_nxt_ext[4:0]);
	assign mel_done     = elapsed >= TIME_BITS'(mel_cur.ms);

	always_comb begin
		sound_on_n     = sound_on_q;
		effect_busy_n  = effect_busy_q;
		effect_sel_n   = effect_sel_q;
		effect_step_n  = effect_step_q;
		step_running_n = step_running_q;
		step_start_n   = step_start_q;
		melody_step_n  = melody_step_q;
		tone_n         = tone_q;
		off_n          = 1'b0;
		unique case (cmd_t'(req_s1.cmd))
			CMD_TICK: begin
				if (!sound_on_q) begin
					tone_n = '0;
				end else if (effect_busy_q) begin
					if (!step_running_q) begin
						step_running_n = 1'b1;
						step_start_n   = now_t;
						tone_n         = eff_cur.hz;
					end else if (eff_done) begin
						step_start_n = now_t;
						if (eff_st_inc >= effect_len(effect_sel_q)) begin
							effect_busy_n  = 1'b0;
							effect_step_n  = '0;
							step_running_n = 1'b0;
							tone_n         = '0;
						end else begin
							effect_step_n = eff_st_inc[1:0];
							tone_n        = eff_nxt.hz;
						end
					end
				end else if (req_s1.music_halted) begin
					tone_n = '0;
				end else if (!step_running_q) begin
					step_running_n = 1'b1;
					step_start_n   = now_t;
					tone_n         = mel_cur.hz;
				end else if (mel_done) begin
					melody_step_n = mel_step_inc;
					step_start_n  = now_t;
					tone_n        = mel_nxt.hz;
				end
			end
			CMD_TRIGGER: begin
				if (sound_on_q && req_s1.effect_id < EFF_W'(EFFECT_NUM)) begin
					effect_busy_n  = 1'b1;
					effect_sel_n   = req_s1.effect_id;
					effect_step_n  = '0;
					step_running_n = 1'b0;
				end
			end
			CMD_MUTE: begin
				sound_on_n     = !sound_on_q;
				effect_busy_n  = 1'b0;
				effect_sel_n   = '0;
				effect_step_n  = '0;
				step_running_n = 1'b0;
				melody_step_n  = '0;
				tone_n         = '0;
				off_n          = sound_on_q;
			end
			CMD_RESTART: begin
				// The start effect is queued right away when sound is on.
				effect_busy_n  = sound_on_q;
				effect_sel_n   = '0;
				effect_step_n  = '0;
				step_running_n = 1'b0;
				melody_step_n  = '0;
				tone_n         = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			rsp_valid_q    <= 1'b0;
			sound_on_q     <= 1'b1;
			effect_busy_q  <= 1'b0;
			effect_sel_q   <= '0;
			effect_step_q  <= '0;
			step_running_q <= 1'b0;
			step_start_q   <= '0;
			melody_step_q  <= '0;
			tone_q         <= '0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q    <= 1'b1;
				sound_on_q     <= sound_on_n;
				effect_busy_q  <= effect_busy_n;
				effect_sel_q   <= effect_sel_n;
				effect_step_q  <= effect_step_n;
				step_running_q <= step_running_n;
				step_start_q   <= step_start_n;
				melody_step_q  <= melody_step_n;
				tone_q         <= tone_n;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req.data;
		end
		if (advance) begin
			rsp_data_q.tone_freq    <= tone_n;
			rsp_data_q.tone_changed <= tone_n != tone_q;
			rsp_data_q.speaker_off  <= off_n;
		end
	end

endmodule

// ----- rtl/core/tems_checker.sv -----
// Port-level assertions for the tone sequencer, bound to its top level.
module tems_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input tems_pkg::out_word_t rsp_data
);
	import tems_pkg::*;

	logic [FREQ_W-1:0] last_freq_q;
	logic [2:0]        pending_q;
	logic              req_take;
	logic              rsp_take;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_freq_q <= '0;
			pending_q   <= '0;
		end else begin
			if (rsp_take) begin
				last_freq_q <= rsp_data.tone_freq;
			end
			pending_q <= pending_q + {2'b0, req_take} - {2'b0, rsp_take};
		end
	end

	// The change flag must agree with the previous delivered frequency.
	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take |-> (rsp_data.tone_changed == (rsp_data.tone_freq != last_freq_q)))
		else $error("tone_changed disagrees with the previous frequency");

	// Turning the speaker off always leaves it silent.
	a_off_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.speaker_off |-> rsp_data.tone_freq == '0)
		else $error("speaker_off with a nonzero frequency");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	// At most two words are in flight, and no result comes without a request.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more words in flight than pipeline stages");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 3'd0)
		else $error("result word offered with no word pending");

endmodule

bind tone_effect_music_sequencer tems_checker u_tems_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ----- tb/tone_effect_music_sequencer_tb.sv -----
// Self-checking testbench for the tone and effect sequencer with its own tone predictor.
module tone_effect_music_sequencer_tb;
	import tems_pkg::*;

	localparam int MELODY_STEPS = MELODY_STEPS_DEF;
	localparam int TIME_BITS    = TIME_BITS_DEF;
	localparam logic [31:0] TIME_MASK = (TIME_BITS >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << TIME_BITS) - 32'd1);
	localparam int RANDOM_WORDS = 1250;
	localparam int QUIET_LIMIT  = 2000;

	typedef struct {
		int unsigned hz;
		int unsigned ms;
	} note_t;

	logic clk;
	logic arst_n;

	tems_chan_if #(.T(in_word_t))  req ();
	tems_chan_if #(.T(out_word_t)) rsp ();

	tone_effect_music_sequencer #(
		.MELODY_STEPS(MELODY_STEPS),
		.TIME_BITS(TIME_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	in_word_t  cmd_q[$];
	out_word_t tone_q[$];
	out_word_t want;

	// Predicted sequencer state.
	bit          spk_on;
	bit          fx_active;
	logic [2:0]  fx_sel;
	int unsigned fx_step;
	bit          note_live;
	logic [31:0] note_start;
	int unsigned tune_pos;
	logic [10:0] tone_now;

	int send_gap;
	int stall_left;
	int quiet_cycles = 0;
	int words_in = 0;
	int words_out = 0;
	int tone_changes = 0;
	int mutes_off = 0;
	int mismatches = 0;
	int directed_words = 0;
	int cmd_seen[4] = '{0, 0, 0, 0};

	function automatic note_t tune_note(int unsigned pos);
		note_t n;
		if (pos % 2 == 1) begin
			n.hz = 0;
			n.ms = 35;
		end else begin
			n.ms = 120;
			case ((pos % 32) / 2)
				0:       n.hz = 165;
				1:       n.hz = 196;
				2:       n.hz = 247;
				3:       n.hz = 330;
				4:       n.hz = 262;
				5:       n.hz = 330;
				6:       n.hz = 392;
				7:       n.hz = 523;
				8:       n.hz = 196;
				9:       n.hz = 247;
				10:      n.hz = 294;
				11:      n.hz = 392;
				12:      n.hz = 147;
				13:      n.hz = 185;
				14:      n.hz = 220;
				default: n.hz = 294;
			endcase
		end
		return n;
	endfunction

	function automatic note_t fx_note(int unsigned sel, int unsigned st);
		note_t n;
		case (sel * 4 + st)
			0:       n = '{659, 70};
			1:       n = '{988, 90};
			4:       n = '{784, 60};
			5:       n = '{988, 60};
			8:       n = '{123, 55};
			12:      n = '{110, 80};
			13:      n = '{82, 80};
			14:      n = '{55, 110};
			16:      n = '{196, 120};
			17:      n = '{147, 140};
			18:      n = '{98, 180};
			20:      n = '{523, 90};
			21:      n = '{659, 90};
			22:      n = '{784, 90};
			23:      n = '{1047, 150};
			default: n = '{0, 0};
		endcase
		return n;
	endfunction

	function automatic int unsigned fx_count(int unsigned sel);
		case (sel)
			0, 1:    return 2;
			2:       return 1;
			3, 4:    return 3;
			default: return 4;
		endcase
	endfunction

	function automatic bit retune(int unsigned hz);
		logic [10:0] h;
		h = hz[10:0];
		if (h == tone_now)
			return 1'b0;
		tone_now = h;
		return 1'b1;
	endfunction

	function automatic void rewind();
		fx_active = 1'b0;
		fx_sel    = '0;
		fx_step   = 0;
		note_live = 1'b0;
		tune_pos  = 0;
	endfunction

	function automatic void arm_effect(logic [2:0] id);
		if (!spk_on || id > 3'd5)
			return;
		fx_active = 1'b1;
		fx_sel    = id;
		fx_step   = 0;
		note_live = 1'b0;
	endfunction

	function automatic bit tick_tone(logic [31:0] now, bit halted);
		note_t       n;
		logic [31:0] span;
		if (!spk_on)
			return retune(0);
		if (fx_active) begin
			n = fx_note(fx_sel % 6, fx_step & 3);
			if (!note_live) begin
				note_live  = 1'b1;
				note_start = now;
				return retune(n.hz);
			end
			span = (now - note_start) & TIME_MASK;
			if (span >= n.ms) begin
				note_start = now;
				// The last step of an effect hands the speaker back in silence.
				if (fx_step + 1 >= fx_count(fx_sel % 6)) begin
					fx_active = 1'b0;
					fx_step   = 0;
					note_live = 1'b0;
					return retune(0);
				end
				fx_step = (fx_step + 1) & 3;
				n = fx_note(fx_sel % 6, fx_step);
				return retune(n.hz);
			end
			return 1'b0;
		end
		if (halted)
			return retune(0);
		n = tune_note(tune_pos);
		if (!note_live) begin
			note_live  = 1'b1;
			note_start = now;
			return retune(n.hz);
		end
		span = (now - note_start) & TIME_MASK;
		if (span >= n.ms) begin
			tune_pos   = (tune_pos + 1) % MELODY_STEPS;
			note_start = now;
			n = tune_note(tune_pos);
			return retune(n.hz);
		end
		return 1'b0;
	endfunction

	function automatic out_word_t advance_sequencer(in_word_t w);
		out_word_t   r;
		logic [31:0] now;
		r   = '0;
		now = w.now_ms & TIME_MASK;
		case (w.cmd)
			CMD_TICK: begin
				r.tone_changed = tick_tone(now, w.music_halted);
			end
			CMD_TRIGGER: begin
				arm_effect(w.effect_id);
			end
			CMD_MUTE: begin
				spk_on = !spk_on;
				rewind();
				r.tone_changed = retune(0);
				r.speaker_off  = !spk_on;
			end
			default: begin
				rewind();
				r.tone_changed = retune(0);
				arm_effect(3'd0);
			end
		endcase
		r.tone_freq = tone_now;
		return r;
	endfunction

	function automatic in_word_t pack_cmd(cmd_t c, logic [31:0] now, logic [2:0] id,
		bit halted);
		in_word_t w;
		w.cmd          = c;
		w.now_ms       = now;
		w.effect_id    = id;
		w.music_halted = halted;
		return w;
	endfunction

	// Stretches without any idling on either side, and none near the end.
	function automatic bit steady_phase();
		return cmd_q.size() < 200 || (cmd_q.size() / 100) % 4 == 1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: one command word per handshake, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data  <= '0;
			send_gap  = 0;
			spk_on     = 1'b1;
			rewind();
			note_start = '0;
			tone_now   = '0;
		end else begin
			if (req.valid && req.ready) begin
				tone_q.push_back(advance_sequencer(req.data));
				words_in++;
				cmd_seen[req.data.cmd]++;
			end
			if (!(req.valid && !req.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (cmd_q.size() > 0 && !steady_phase() &&
					$urandom_range(0, 15) == 0) begin
					send_gap = $urandom_range(0, 17);
					req.valid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					req.data  <= cmd_q.pop_front();
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each result word with the oldest predicted tone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				words_out++;
				if (tone_q.size() == 0) begin
					if (mismatches < 10)
						$display({"ERROR: result word with no prediction pending: ",
							"freq=%0d chg=%0b off=%0b"},
							rsp.data.tone_freq, rsp.data.tone_changed,
							rsp.data.speaker_off);
					mismatches++;
				end else begin
					want = tone_q.pop_front();
					if (want.tone_changed) tone_changes++;
					if (want.speaker_off) mutes_off++;
					if (rsp.data.tone_freq !== want.tone_freq ||
						rsp.data.tone_changed !== want.tone_changed ||
						rsp.data.speaker_off !== want.speaker_off) begin
						if (mismatches < 10)
							$display({"ERROR: result %0d: expected freq=%0d chg=%0b ",
								"off=%0b, got freq=%0d chg=%0b off=%0b"},
								words_out, want.tone_freq, want.tone_changed,
								want.speaker_off, rsp.data.tone_freq,
								rsp.data.tone_changed, rsp.data.speaker_off);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (!steady_phase() && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(0, 17);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
		$display("tone_effect_music_sequencer verification failed");
		$finish;
	end

	initial begin
		logic [31:0] t_ms;
		int          roll;
		int          pick;
		bit          gen_muted;
		in_word_t    w;
		logic [63:0] raw_bits;

		arst_n <= 1'b0;

		// Directed: melody start and advance, every effect, ignored triggers,
		// halt, mute handling, restart and a timestamp that wraps.
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd0, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd119, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd120, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'hFFFF_FFFF, 3'd7, 1'b1));
		cmd_q.push_back(pack_cmd(CMD_TRIGGER, 32'd0, 3'd6, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TRIGGER, 32'd0, 3'd7, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TRIGGER, 32'd0, 3'd5, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd1000, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd1090, 3'd0, 1'b1));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd1180, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd1270, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd1420, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_MUTE, 32'd0, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TRIGGER, 32'd0, 3'd3, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'd1500, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_MUTE, 32'd0, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_RESTART, 32'd0, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'hFFFF_FFF0, 3'd0, 1'b0));
		cmd_q.push_back(pack_cmd(CMD_TICK, 32'h0000_0036, 3'd0, 1'b0));
		for (int id = 1; id <= 4; id++) begin
			cmd_q.push_back(pack_cmd(CMD_TRIGGER, 32'd0, id[2:0], 1'b0));
			cmd_q.push_back(pack_cmd(CMD_TICK, 32'd4000 + id, 3'd0, 1'b0));
		end
		directed_words = cmd_q.size();

		// Random: mostly ticks with a coherent clock so melody and effects run
		// through their steps, mixed with commands and raw noise words.
		t_ms      = $urandom;
		gen_muted = 1'b0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			roll = $urandom_range(0, 99);
			if (gen_muted && roll < 40) begin
				cmd_q.push_back(pack_cmd(CMD_MUTE, $urandom, 3'($urandom), 1'($urandom)));
				gen_muted = 1'b0;
			end else if (roll < 68) begin
				pick = $urandom_range(0, 19);
				if (pick < 12)
					t_ms += 32'($urandom_range(0, 40));
				else if (pick < 18)
					t_ms += 32'($urandom_range(40, 200));
				else if (pick == 18)
					t_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 150));
				else
					t_ms += $urandom;
				cmd_q.push_back(pack_cmd(CMD_TICK, t_ms, 3'($urandom),
					$urandom_range(0, 11) == 0));
			end else if (roll < 80) begin
				pick = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 5) :
					$urandom_range(6, 7);
				cmd_q.push_back(pack_cmd(CMD_TRIGGER, $urandom, pick[2:0], 1'($urandom)));
			end else if (roll < 85) begin
				cmd_q.push_back(pack_cmd(CMD_MUTE, $urandom, 3'($urandom), 1'($urandom)));
				gen_muted = !gen_muted;
			end else if (roll < 89) begin
				cmd_q.push_back(pack_cmd(CMD_RESTART, $urandom, 3'($urandom),
					1'($urandom)));
			end else begin
				raw_bits = {$urandom, $urandom};
				w = raw_bits[$bits(in_word_t)-1:0];
				if (w.cmd == CMD_MUTE)
					gen_muted = !gen_muted;
				cmd_q.push_back(w);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || req.valid)
			@(posedge clk);
		while (tone_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display({"Run covered %0d command words (%0d directed): %0d ticks, ",
			"%0d triggers, %0d mute toggles, %0d restarts."},
			words_in, directed_words, cmd_seen[CMD_TICK], cmd_seen[CMD_TRIGGER],
			cmd_seen[CMD_MUTE], cmd_seen[CMD_RESTART]);
		$display({"Checked %0d result words with %0d tone changes and ",
			"%0d speaker-off events; %0d mismatches."},
			words_out, tone_changes, mutes_off, mismatches);
		if (mismatches == 0 && tone_q.size() == 0)
			$display("tone_effect_music_sequencer verification clean");
		else
			$display("tone_effect_music_sequencer verification failed");
		$finish;
	end

endmodule
